/* src/bmp_grey_pkg.sv */
// ============================================================================
// bmp_grey_pkg
// Shared types and constants for the bitmap raster to greyscale converter.
// ============================================================================
package bmp_grey_pkg;

    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int BPP_W      = 6;
    localparam int DIM_W      = 13;

    localparam logic [CFG_IDX_W-1:0] REG_BPP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    localparam logic [BPP_W-1:0] BPP_MONO = 6'd1;
    localparam logic [BPP_W-1:0] BPP_BYTE = 6'd8;
    localparam logic [BPP_W-1:0] BPP_RGB  = 6'd24;

    localparam logic [BPP_W-1:0] RST_BPP = BPP_BYTE;
    localparam logic [DIM_W-1:0] RST_DIM = 13'd1;

    localparam logic [15:0] COEF_R = 16'd19595;
    localparam logic [15:0] COEF_G = 16'd38470;
    localparam logic [15:0] COEF_B = 16'd7471;

    localparam int PROD_W = 24;

    localparam int CMD_DEPTH = 4;
    localparam int OUT_DEPTH = 4;

    typedef enum logic [1:0] {
        KIND_MONO,
        KIND_BYTE,
        KIND_ZERO,
        KIND_LUMA
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic [7:0] blue;
        logic [7:0] green;
        logic [2:0] last_k;
        logic       row_last;
        logic       img_last;
    } t_cmd;

    typedef struct packed {
        logic [7:0] grey;
        logic       row_end;
        logic       image_end;
    } t_pix;

endpackage

/* src/bmp_grey_fifo.sv */
// ============================================================================
// bmp_grey_fifo
// Small register-based first-in first-out queue with an occupancy count.
// ============================================================================
module bmp_grey_fifo
    import bmp_grey_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    output logic                       o_full,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, n_wr;
    logic [PW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

/* src/bmp_grey_front.sv */
// ============================================================================
// bmp_grey_front
// Holds the configuration, tracks the position in the stored raster and
// turns each accepted byte into a pixel command or swallows it.
// ============================================================================
module bmp_grey_front
    import bmp_grey_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_push,
    input  logic [7:0]            i_data_byte,
    output logic                  o_full,
    input  logic                  i_cmd_full,
    output logic                  o_cmd_push,
    output t_cmd                  o_cmd
);

    localparam int IDXW = $clog2(3 * MAX_WIDTH + 4);
    localparam int WEXT = (IDXW > DIM_W) ? IDXW : DIM_W;
    localparam int HMW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int HEXT = (HMW + 1 > DIM_W) ? HMW + 1 : DIM_W;

    logic [BPP_W-1:0] r_bpp, n_bpp;
    logic [DIM_W-1:0] r_width, n_width;
    logic [DIM_W-1:0] r_height, n_height;
    logic             r_settle;
    logic             restart;

    logic [IDXW-1:0]  r_data_last, n_data_last;
    logic [IDXW-1:0]  r_pad_last, n_pad_last;
    logic [2:0]       r_mono_last, n_mono_last;
    logic [HMW-1:0]   r_h_last, n_h_last;

    logic [IDXW-1:0]  r_idx, n_idx;
    logic [HMW-1:0]   r_row, n_row;
    logic [1:0]       r_phase, n_phase;
    logic [7:0]       r_blue, n_blue;
    logic [7:0]       r_green, n_green;

    logic [WEXT-1:0]  w_ext;
    logic [WEXT-1:0]  wm1;
    logic [WEXT-1:0]  dl_ext;
    logic [HEXT-1:0]  h_ext;
    logic [HEXT-1:0]  hm1;

    logic             accept;
    logic             in_data;
    logic             data_last;
    logic             img_last;
    logic             is_mono;
    logic             is_rgb;
    logic             is_byte;

    assign o_full  = r_settle || i_cmd_full;
    assign accept  = i_push && !o_full;
    assign is_mono = (r_bpp == BPP_MONO);
    assign is_rgb  = (r_bpp == BPP_RGB);
    assign is_byte = (r_bpp == BPP_BYTE);

    // Row geometry, refreshed every cycle from the configuration registers.
    always_comb begin
        w_ext = WEXT'(r_width);
        if (r_width == '0) begin
            wm1 = '0;
        end else if (w_ext > WEXT'(MAX_WIDTH)) begin
            wm1 = WEXT'(MAX_WIDTH - 1);
        end else begin
            wm1 = w_ext - 1'b1;
        end
        if (is_mono) begin
            dl_ext = wm1 >> 3;
        end else if (is_rgb) begin
            dl_ext = wm1 + (wm1 << 1) + WEXT'(2);
        end else begin
            dl_ext = wm1;
        end
        n_data_last = IDXW'(dl_ext);
        n_pad_last  = IDXW'(dl_ext) | IDXW'(3);
        n_mono_last = wm1[2:0];

        h_ext = HEXT'(r_height);
        if (r_height == '0) begin
            hm1 = '0;
        end else if (h_ext > HEXT'(MAX_HEIGHT)) begin
            hm1 = HEXT'(MAX_HEIGHT - 1);
        end else begin
            hm1 = h_ext - 1'b1;
        end
        n_h_last = HMW'(hm1);
    end

    always_comb begin
        n_bpp    = r_bpp;
        n_width  = r_width;
        n_height = r_height;
        restart  = 1'b0;
        if (i_cfg_we) begin
            case (i_cfg_index)
                REG_BPP: begin
                    n_bpp   = i_cfg_data[BPP_W-1:0];
                    restart = 1'b1;
                end
                REG_WIDTH: begin
                    n_width = i_cfg_data;
                    restart = 1'b1;
                end
                REG_HEIGHT: begin
                    n_height = i_cfg_data;
                    restart  = 1'b1;
                end
                default: begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    assign in_data   = (r_idx <= r_data_last);
    assign data_last = (r_idx == r_data_last);
    assign img_last  = data_last && (r_row == r_h_last);

    always_comb begin
        n_idx          = r_idx;
        n_row          = r_row;
        n_phase        = r_phase;
        n_blue         = r_blue;
        n_green        = r_green;
        o_cmd_push     = 1'b0;
        o_cmd.kind     = KIND_BYTE;
        o_cmd.data     = i_data_byte;
        o_cmd.blue     = r_blue;
        o_cmd.green    = r_green;
        o_cmd.last_k   = '0;
        o_cmd.row_last = data_last;
        o_cmd.img_last = img_last;

        if (is_mono) begin
            o_cmd.kind   = KIND_MONO;
            o_cmd.last_k = data_last ? r_mono_last : 3'd7;
        end else if (is_rgb) begin
            o_cmd.kind = KIND_LUMA;
        end else if (!is_byte) begin
            o_cmd.kind = KIND_ZERO;
        end

        if (accept) begin
            if (in_data) begin
                if (is_rgb) begin
                    case (r_phase)
                        2'd0: begin
                            n_blue  = i_data_byte;
                            n_phase = 2'd1;
                        end
                        2'd1: begin
                            n_green = i_data_byte;
                            n_phase = 2'd2;
                        end
                        default: begin
                            o_cmd_push = 1'b1;
                            n_phase    = 2'd0;
                        end
                    endcase
                end else begin
                    o_cmd_push = 1'b1;
                end
            end
            if (r_idx == r_pad_last) begin
                n_idx   = '0;
                n_phase = 2'd0;
                n_row   = (r_row == r_h_last) ? '0 : r_row + 1'b1;
            end else begin
                n_idx = r_idx + 1'b1;
            end
        end

        if (restart) begin
            n_idx   = '0;
            n_row   = '0;
            n_phase = 2'd0;
            n_blue  = '0;
            n_green = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp    <= RST_BPP;
            r_width  <= RST_DIM;
            r_height <= RST_DIM;
            r_settle <= 1'b1;
            r_idx    <= '0;
            r_row    <= '0;
            r_phase  <= 2'd0;
            r_blue   <= '0;
            r_green  <= '0;
        end else begin
            r_bpp    <= n_bpp;
            r_width  <= n_width;
            r_height <= n_height;
            r_settle <= i_cfg_we;
            r_idx    <= n_idx;
            r_row    <= n_row;
            r_phase  <= n_phase;
            r_blue   <= n_blue;
            r_green  <= n_green;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data_last <= n_data_last;
        r_pad_last  <= n_pad_last;
        r_mono_last <= n_mono_last;
        r_h_last    <= n_h_last;
    end

endmodule

/* src/bmp_grey_back.sv */
// ============================================================================
// bmp_grey_back
// Expands commands into one pixel per cycle while the output queue has room,
// computes luma for colour pixels and queues the finished words for the consumer.
// ============================================================================
module bmp_grey_back
    import bmp_grey_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_empty,
    input  t_cmd       i_cmd,
    output logic       o_cmd_pop,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [7:0] o_grey,
    output logic       o_row_end,
    output logic       o_image_end
);

    localparam int OCW = $clog2(OUT_DEPTH + 1);

    t_cmd              r_cur, n_cur;
    logic              r_cur_valid, n_cur_valid;
    logic [2:0]        r_k, n_k;

    logic              r_s1_valid;
    logic              r_s1_luma, n_s1_luma;
    logic [7:0]        r_s1_grey, n_s1_grey;
    logic              r_s1_row_end, n_s1_row_end;
    logic              r_s1_img_end, n_s1_img_end;
    logic [PROD_W-1:0] r_s1_pr, n_s1_pr;
    logic [PROD_W-1:0] r_s1_pg, n_s1_pg;
    logic [PROD_W-1:0] r_s1_pb, n_s1_pb;

    logic [PROD_W-1:0] luma_sum;
    logic [OCW-1:0]    out_count;
    logic [OCW:0]      pending;
    logic              space;
    logic              issue;
    logic              last;
    t_pix              out_wdata;
    t_pix              out_rdata;

    assign pending   = (OCW + 1)'(out_count) + (OCW + 1)'(r_s1_valid);
    assign space     = (pending < (OCW + 1)'(OUT_DEPTH));
    assign issue     = r_cur_valid && space;
    assign last      = (r_k == r_cur.last_k);
    assign o_cmd_pop = !i_cmd_empty && (!r_cur_valid || (issue && last));

    always_comb begin
        n_cur       = r_cur;
        n_cur_valid = r_cur_valid;
        n_k         = r_k;
        if (o_cmd_pop) begin
            n_cur       = i_cmd;
            n_cur_valid = 1'b1;
            n_k         = '0;
        end else if (issue && last) begin
            n_cur_valid = 1'b0;
        end else if (issue) begin
            n_k = r_k + 1'b1;
        end
    end

    always_comb begin
        n_s1_luma    = 1'b0;
        n_s1_grey    = '0;
        n_s1_row_end = r_cur.row_last && last;
        n_s1_img_end = r_cur.img_last && last;
        n_s1_pr      = PROD_W'(COEF_R) * PROD_W'(r_cur.data);
        n_s1_pg      = PROD_W'(COEF_G) * PROD_W'(r_cur.green);
        n_s1_pb      = PROD_W'(COEF_B) * PROD_W'(r_cur.blue);
        case (r_cur.kind)
            KIND_MONO: begin
                n_s1_grey = r_cur.data[3'd7 - r_k] ? 8'hFF : 8'h00;
            end
            KIND_BYTE: begin
                n_s1_grey = r_cur.data;
            end
            KIND_LUMA: begin
                n_s1_luma = 1'b1;
            end
            default: begin
                n_s1_grey = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_k         <= '0;
            r_s1_valid  <= 1'b0;
        end else begin
            r_cur_valid <= n_cur_valid;
            r_k         <= n_k;
            r_s1_valid  <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        if (issue) begin
            r_s1_luma    <= n_s1_luma;
            r_s1_grey    <= n_s1_grey;
            r_s1_row_end <= n_s1_row_end;
            r_s1_img_end <= n_s1_img_end;
            r_s1_pr      <= n_s1_pr;
            r_s1_pg      <= n_s1_pg;
            r_s1_pb      <= n_s1_pb;
        end
    end

    assign luma_sum            = r_s1_pr + r_s1_pg + r_s1_pb;
    assign out_wdata.grey      = r_s1_luma ? luma_sum[PROD_W-1:PROD_W-8] : r_s1_grey;
    assign out_wdata.row_end   = r_s1_row_end;
    assign out_wdata.image_end = r_s1_img_end;

    bmp_grey_fifo #(
        .WIDTH ($bits(t_pix)),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s1_valid),
        .i_data  (out_wdata),
        .o_full  (),
        .i_pop   (i_pop),
        .o_data  (out_rdata),
        .o_empty (o_empty),
        .o_count (out_count)
    );

    assign o_grey      = out_rdata.grey;
    assign o_row_end   = out_rdata.row_end;
    assign o_image_end = out_rdata.image_end;

endmodule

/* src/bmp_raster_to_greyscale_top.sv */
// ============================================================================
// bmp_raster_to_greyscale_top
// Converts the stored pixel bytes of an uncompressed bitmap into one grey
// word per pixel, with row and image end marks.
//
// Channel  Direction  Handshake             Payload
// input    in         push / full           i_data_byte
// result   out        pop / empty           o_grey, o_row_end, o_image_end
// config   in         i_cfg_valid / ready   i_cfg_index, i_cfg_data
//
// At 8 bpp and for other depths one byte a cycle is taken while full is low
// and, while pop keeps up, one word a cycle is delivered; at 24 bpp three bytes give one word.
// At 1 bpp a byte yields up to eight words, one per cycle from the unpacker
// in the back end while the output queue has room, so once the command queue
// has filled, full stays high until the back end frees a slot for a new byte.
// A pixel's data passes the command queue, the current command and stage-one registers
// and the output queue. Reset is synchronous; full stays high for one cycle after
// reset and after each configuration write while the row geometry is recomputed.
// ============================================================================
module bmp_raster_to_greyscale_top
    import bmp_grey_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [7:0]            i_data_byte,
    output logic                  empty,
    input  logic                  pop,
    output logic [7:0]            o_grey,
    output logic                  o_row_end,
    output logic                  o_image_end,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic cmd_push;
    logic cmd_full;
    logic cmd_empty;
    logic cmd_pop;
    t_cmd cmd_wdata;
    t_cmd cmd_rdata;

    assign o_cfg_ready = 1'b1;

    bmp_grey_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .i_data_byte (i_data_byte),
        .o_full      (full),
        .i_cmd_full  (cmd_full),
        .o_cmd_push  (cmd_push),
        .o_cmd       (cmd_wdata)
    );

    bmp_grey_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_wdata),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_rdata),
        .o_empty (cmd_empty),
        .o_count ()
    );

    bmp_grey_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (cmd_rdata),
        .o_cmd_pop   (cmd_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_grey      (o_grey),
        .o_row_end   (o_row_end),
        .o_image_end (o_image_end)
    );

endmodule
